### src/groc_pkg.sv
// ----------------------------------------------------------------------------
// groc_pkg
// Shared types and constants for the grid rectangle occupancy map.
// ----------------------------------------------------------------------------
package groc_pkg;

    // Default sizes for the top-level parameters
    localparam int unsigned DEF_MAX_COLUMNS = 16;
    localparam int unsigned DEF_MAX_ROWS    = 16;
    localparam int unsigned DEF_TAG_BITS    = 8;

    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT      = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITEM_SIZE    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_RESTRICTION = 4'd3;

    // Configuration reset values
    localparam logic [4:0] GRID_WIDTH_RST       = 5'd4;
    localparam logic [4:0] GRID_HEIGHT_RST      = 5'd4;
    localparam logic [2:0] MAX_ITEM_SIZE_RST    = 3'd7;
    localparam logic [3:0] TYPE_RESTRICTION_RST = 4'd0;

    typedef enum logic [2:0] {
        OP_CHECK  = 3'd0,
        OP_PLACE  = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        STS_OK           = 3'd0,
        STS_BAD_INDEX    = 3'd1,
        STS_TOO_LARGE    = 3'd2,
        STS_WRONG_TYPE   = 3'd3,
        STS_BAD_DIMS     = 3'd4,
        STS_OUT_OF_BOUNDS = 3'd5,
        STS_OCCUPIED     = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        CS_IDLE,
        CS_SWEEP,
        CS_CLEAR,
        CS_DECODE,
        CS_DIVIDE,
        CS_BOUNDS,
        CS_WALK,
        CS_DRAIN,
        CS_READ,
        CS_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] top_left;
        logic [4:0] item_width;
        logic [4:0] item_height;
        logic [7:0] item_tag;
        logic [2:0] item_size_class;
        logic [3:0] item_type;
    } groc_req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] cell_owner;
    } groc_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    sweep_init;
        logic    sweep_step;
        logic    div_init;
        logic    div_step;
        logic    walk_init;
        logic    walk_step;
        logic    read_issue;
        logic    res_load;
        logic    res_owner;
        status_t res_status;
    } groc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       idx_ok;
        logic       pre_fail;
        status_t    pre_status;
        logic       div_last;
        logic       oob;
        logic       dims_zero;
        logic       walk_last;
        logic       occ_hit;
        logic       sweep_last;
        logic       clear_pend;
    } groc_stat_t;

endpackage

### src/groc_ram.sv
// ----------------------------------------------------------------------------
// groc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module groc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/groc_ctrl.sv
// ----------------------------------------------------------------------------
// groc_ctrl
// Sequencer: decodes a request and steps the datapath through the
// divide, bounds, cell walk, read and clearing phases.
// ----------------------------------------------------------------------------
module groc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  groc_pkg::groc_stat_t stat,
    output groc_pkg::groc_cmd_t  cmd,
    output logic                 busy,
    output logic                 done
);
    import groc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            CS_IDLE:
            begin
                if (stat.clear_pend)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = CS_SWEEP;
                end
                else if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = CS_DECODE;
                end
            end
            CS_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            CS_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_OK;
                    state_next     = CS_RESULT;
                end
            end
            CS_DECODE:
            begin
                case (stat.opcode)
                    OP_CHECK:
                    begin
                        if (!stat.idx_ok)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_BAD_INDEX;
                            state_next     = CS_RESULT;
                        end
                        else if (stat.pre_fail)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = stat.pre_status;
                            state_next     = CS_RESULT;
                        end
                        else
                        begin
                            cmd.div_init = 1'b1;
                            state_next   = CS_DIVIDE;
                        end
                    end
                    OP_PLACE, OP_REMOVE:
                    begin
                        if (!stat.idx_ok)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_BAD_INDEX;
                            state_next     = CS_RESULT;
                        end
                        else
                        begin
                            cmd.div_init = 1'b1;
                            state_next   = CS_DIVIDE;
                        end
                    end
                    OP_READ:
                    begin
                        if (!stat.idx_ok)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_BAD_INDEX;
                            state_next     = CS_RESULT;
                        end
                        else
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = CS_READ;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.sweep_init = 1'b1;
                        state_next     = CS_CLEAR;
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = STS_OK;
                        state_next     = CS_RESULT;
                    end
                endcase
            end
            CS_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = CS_BOUNDS;
                end
            end
            CS_BOUNDS:
            begin
                if (stat.oob)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_OUT_OF_BOUNDS;
                    state_next     = CS_RESULT;
                end
                else if (stat.dims_zero)
                begin
                    // empty rectangle on place/remove touches nothing
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_OK;
                    state_next     = CS_RESULT;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = CS_WALK;
                end
            end
            CS_WALK:
            begin
                if (stat.occ_hit)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = STS_OCCUPIED;
                    state_next     = CS_RESULT;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    if (stat.walk_last)
                    begin
                        if (stat.opcode == OP_PLACE)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STS_OK;
                            state_next     = CS_RESULT;
                        end
                        else
                        begin
                            state_next = CS_DRAIN;
                        end
                    end
                end
            end
            CS_DRAIN:
            begin
                // last read comes back here; remove writes it back meanwhile
                cmd.res_load   = 1'b1;
                cmd.res_status = stat.occ_hit ? STS_OCCUPIED : STS_OK;
                state_next     = CS_RESULT;
            end
            CS_READ:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_owner  = 1'b1;
                cmd.res_status = STS_OK;
                state_next     = CS_RESULT;
            end
            CS_RESULT:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != CS_IDLE) || stat.clear_pend;
    assign done = (state_reg == CS_RESULT);

endmodule

### src/groc_dp.sv
// ----------------------------------------------------------------------------
// groc_dp
// Datapath: configuration registers, request register, restoring divider
// for row/column, rectangle walk counters, clearing counter and the
// cell store port logic.
// ----------------------------------------------------------------------------
module groc_dp #(
    parameter int unsigned MAX_COLUMNS = groc_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = groc_pkg::DEF_MAX_ROWS,
    parameter int unsigned TAG_BITS    = groc_pkg::DEF_TAG_BITS,
    localparam int unsigned CELL_COUNT = MAX_COLUMNS * MAX_ROWS,
    localparam int unsigned ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  groc_pkg::groc_req_t                 req,
    input  logic                                cfg_wr,
    input  logic [groc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [groc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  groc_pkg::groc_cmd_t                 cmd,
    output groc_pkg::groc_stat_t                stat,
    output groc_pkg::groc_rsp_t                 result,
    output logic                                ram_we,
    output logic [ADDR_W-1:0]                   ram_waddr,
    output logic [TAG_BITS-1:0]                 ram_wdata,
    output logic [ADDR_W-1:0]                   ram_raddr,
    input  logic [TAG_BITS-1:0]                 ram_rdata
);
    import groc_pkg::*;

    // grid registers are 5 bits wide, so never more than 31 in use
    localparam int unsigned COL_CAP = (MAX_COLUMNS > 31) ? 31 : MAX_COLUMNS;
    localparam int unsigned ROW_CAP = (MAX_ROWS > 31) ? 31 : MAX_ROWS;

    logic [4:0]          grid_width_reg;
    logic [4:0]          grid_height_reg;
    logic [2:0]          max_size_reg;
    logic [3:0]          type_restr_reg;
    logic                clear_pend_reg;
    logic                pipe_valid_reg;

    groc_req_t           req_reg;
    logic [4:0]          rem_reg;
    logic [7:0]          dvd_reg;
    logic [2:0]          div_cnt_reg;
    logic [4:0]          x_cnt_reg;
    logic [4:0]          y_cnt_reg;
    logic [ADDR_W-1:0]   row_base_reg;
    logic [ADDR_W-1:0]   pipe_addr_reg;
    logic [ADDR_W-1:0]   sweep_cnt_reg;
    status_t             status_reg;
    logic [7:0]          owner_reg;

    logic [4:0]          cols;
    logic [4:0]          rows;
    logic [9:0]          cell_total;
    logic [5:0]          div_trial;
    logic                div_ge;
    logic [ADDR_W-1:0]   walk_addr;
    logic                x_end;
    logic                y_end;
    logic [TAG_BITS-1:0] tag_val;
    logic                pre_fail;
    status_t             pre_status;

    assign cols = (grid_width_reg > 5'(COL_CAP)) ? 5'(COL_CAP) : grid_width_reg;
    assign rows = (grid_height_reg > 5'(ROW_CAP)) ? 5'(ROW_CAP) : grid_height_reg;
    assign cell_total = 10'(cols) * 10'(rows);
    assign tag_val = TAG_BITS'(req_reg.item_tag);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            max_size_reg    <= MAX_ITEM_SIZE_RST;
            type_restr_reg  <= TYPE_RESTRICTION_RST;
            clear_pend_reg  <= 1'b1;   // store is swept once after reset
            pipe_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.sweep_init)
            begin
                clear_pend_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_GRID_WIDTH:
                    begin
                        grid_width_reg <= cfg_data[4:0];
                        clear_pend_reg <= 1'b1;
                    end
                    CFG_GRID_HEIGHT:
                    begin
                        grid_height_reg <= cfg_data[4:0];
                        clear_pend_reg  <= 1'b1;
                    end
                    CFG_MAX_ITEM_SIZE:
                    begin
                        max_size_reg <= cfg_data[2:0];
                    end
                    CFG_TYPE_RESTRICTION:
                    begin
                        type_restr_reg <= cfg_data[3:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            pipe_valid_reg <= cmd.walk_step && (req_reg.opcode != OP_PLACE);
        end
    end

    // Check-only tests ahead of the bounds test, in priority order
    always_comb
    begin
        pre_fail   = 1'b1;
        pre_status = STS_OK;
        if (req_reg.item_size_class > max_size_reg)
        begin
            pre_status = STS_TOO_LARGE;
        end
        else if (type_restr_reg != 4'd0 && req_reg.item_type != type_restr_reg)
        begin
            pre_status = STS_WRONG_TYPE;
        end
        else if (req_reg.item_width == 5'd0 || req_reg.item_height == 5'd0)
        begin
            pre_status = STS_BAD_DIMS;
        end
        else
        begin
            pre_fail = 1'b0;
        end
    end

    // Restoring divide of top_left by the column count, one bit a cycle.
    // Quotient shifts into dvd_reg, leaving row in dvd_reg, column in rem_reg.
    assign div_trial = {rem_reg, dvd_reg[7]};
    assign div_ge    = div_trial >= {1'b0, cols};

    assign walk_addr = row_base_reg + ADDR_W'(x_cnt_reg);
    assign x_end     = x_cnt_reg == (req_reg.item_width - 5'd1);
    assign y_end     = y_cnt_reg == (req_reg.item_height - 5'd1);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end

        if (cmd.div_init)
        begin
            rem_reg     <= 5'd0;
            dvd_reg     <= req_reg.top_left;
            div_cnt_reg <= 3'd0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= div_ge ? 5'(div_trial - {1'b0, cols}) : div_trial[4:0];
            dvd_reg     <= {dvd_reg[6:0], div_ge};
            div_cnt_reg <= div_cnt_reg + 3'd1;
        end

        if (cmd.walk_init)
        begin
            x_cnt_reg    <= 5'd0;
            y_cnt_reg    <= 5'd0;
            row_base_reg <= ADDR_W'(req_reg.top_left);
        end
        else if (cmd.walk_step)
        begin
            if (x_end)
            begin
                x_cnt_reg    <= 5'd0;
                y_cnt_reg    <= y_cnt_reg + 5'd1;
                row_base_reg <= row_base_reg + ADDR_W'(cols);
            end
            else
            begin
                x_cnt_reg <= x_cnt_reg + 5'd1;
            end
        end
        pipe_addr_reg <= walk_addr;

        if (cmd.sweep_init)
        begin
            sweep_cnt_reg <= '0;
        end
        else if (cmd.sweep_step)
        begin
            sweep_cnt_reg <= sweep_cnt_reg + ADDR_W'(1);
        end

        if (cmd.res_load)
        begin
            status_reg <= cmd.res_status;
            owner_reg  <= cmd.res_owner ? 8'(ram_rdata) : 8'd0;
        end
    end

    // Store port: sweep, place writes, remove write-back in the cycle after the read
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_cnt_reg;
        ram_wdata = '0;
        if (cmd.sweep_step)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.walk_step && req_reg.opcode == OP_PLACE)
        begin
            ram_we    = 1'b1;
            ram_waddr = walk_addr;
            ram_wdata = tag_val;
        end
        else if (pipe_valid_reg && req_reg.opcode == OP_REMOVE && ram_rdata == tag_val)
        begin
            ram_we    = 1'b1;
            ram_waddr = pipe_addr_reg;
        end
    end

    assign ram_raddr = cmd.read_issue ? ADDR_W'(req_reg.top_left) : walk_addr;

    always_comb
    begin
        stat.opcode     = req_reg.opcode;
        stat.idx_ok     = {2'b00, req_reg.top_left} < cell_total;
        stat.pre_fail   = pre_fail;
        stat.pre_status = pre_status;
        stat.div_last   = div_cnt_reg == 3'd7;
        stat.oob        = ((6'(rem_reg) + 6'(req_reg.item_width)) > 6'(cols))
                       || ((9'(dvd_reg) + 9'(req_reg.item_height)) > 9'(rows));
        stat.dims_zero  = (req_reg.item_width == 5'd0) || (req_reg.item_height == 5'd0);
        stat.walk_last  = x_end && y_end;
        stat.occ_hit    = pipe_valid_reg && (req_reg.opcode == OP_CHECK)
                       && (ram_rdata != '0);
        stat.sweep_last = sweep_cnt_reg == ADDR_W'(CELL_COUNT - 1);
        stat.clear_pend = clear_pend_reg;
    end

    assign result.status     = status_reg;
    assign result.cell_owner = owner_reg;

endmodule

### src/grid_rectangle_occupancy_map.sv
// ----------------------------------------------------------------------------
// grid_rectangle_occupancy_map
// Occupancy grid of item tags with check, place, remove, read and clear.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and must be taken
// then, since the block cannot be stalled. Check, place and remove run the
// row/column divider, then a bounds test, then walk the rectangle through
// the single store port one cell per cycle; check stops early at the first
// occupied cell. Read fetches one cell, and clear sweeps the whole store.
// Out-of-bounds requests and empty place/remove rectangles end after the
// bounds test, and requests that fail an early test end at decode. After
// reset, and after each write of grid_width or grid_height, all
// MAX_COLUMNS*MAX_ROWS cells of the store are swept to zero with busy high;
// configuration writes are always taken (cfg_ready stays high).
module grid_rectangle_occupancy_map #(
    parameter int unsigned MAX_COLUMNS = groc_pkg::DEF_MAX_COLUMNS,
    parameter int unsigned MAX_ROWS    = groc_pkg::DEF_MAX_ROWS,
    parameter int unsigned TAG_BITS    = groc_pkg::DEF_TAG_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  groc_pkg::groc_req_t              req,
    output logic                             done,
    output groc_pkg::groc_rsp_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [groc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [groc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import groc_pkg::*;

    localparam int unsigned CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
    localparam int unsigned ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    groc_cmd_t           cmd;
    groc_stat_t          stat;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [TAG_BITS-1:0] ram_wdata;
    logic [TAG_BITS-1:0] ram_rdata;

    assign cfg_ready = 1'b1;

    groc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    groc_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .TAG_BITS    (TAG_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    groc_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

### src/groc_checker.sv
// ----------------------------------------------------------------------------
// groc_checker
// Port-level checks on request acceptance and result timing.
// ----------------------------------------------------------------------------
module groc_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input groc_pkg::groc_rsp_t result
);
    import groc_pkg::*;

    // a result only shows while a transaction is in progress
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result in the cycle after acceptance");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_fail_no_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != STS_OK) |-> (result.cell_owner == 8'd0))
        else $error("owner reported on failed transaction");

endmodule

bind grid_rectangle_occupancy_map groc_checker u_checker (.*);
